[rtl/core/sre_pkg.sv]
// shared types, constants and helpers for the sharpe ratio engine
// no dependencies; imported by every module of the block
package sre_pkg;

  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned DSR_W       = 32;
  localparam int unsigned REM_W       = 36;
  localparam int unsigned ITER_W      = 7;

  // sqrt(252) in Q16.16, rounded to nearest
  localparam logic [21:0] SQRT252_Q16 = 22'd1040352;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SAMPLES - 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_RET   = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DEV = 2'd2;

  localparam logic [ITER_W-1:0] ITERS_RET  = ITER_W'(48);
  localparam logic [ITER_W-1:0] ITERS_FULL = ITER_W'(64);
  localparam logic [ITER_W-1:0] ITERS_SQRT = ITER_W'(32);

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic              start;
    unit_op_e          op;
    logic [ITER_W-1:0] iters;
  } unit_req_t;

  // signed saturation of a sign and magnitude pair to 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic [ACC_W-1:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag > ACC_W'(64'h8000_0000)) res = 32'h8000_0000;
      else res = 32'(-mag[31:0]);
    end else begin
      if (mag > ACC_W'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/sre_iter_unit.sv]
// shared iterative unit: restoring unsigned divide or digit-by-digit square root
// one quotient bit or one root bit per cycle; uses sre_pkg
module sre_iter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sre_pkg::unit_req_t            req_i,
  input  logic [sre_pkg::ACC_W-1:0]     opa_i,
  input  logic [sre_pkg::DSR_W-1:0]     opb_i,
  output logic                          done_o,
  output logic [sre_pkg::ACC_W-1:0]     quot_o,
  output logic [sre_pkg::DSR_W-1:0]     root_o
);
  import sre_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  unit_op_e          op_q, op_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DSR_W-1:0]  dsr_q, dsr_d;
  logic [DSR_W-1:0]  root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;

  // one shared subtract and compare for both operations
  always_comb begin
    if (op_q == OP_SQRT) begin
      rem_sh = {rem_q[REM_W-3:0], acc_q[ACC_W-1 -: 2]};
      trial  = REM_W'({root_q, 2'b01});
    end else begin
      rem_sh = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
      trial  = REM_W'(dsr_q);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[REM_W];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    dsr_d  = dsr_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = req_i.iters;
      acc_d  = opa_i;
      dsr_d  = opb_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : rem_sh;
      if (op_q == OP_SQRT) begin
        acc_d  = {acc_q[ACC_W-3:0], 2'b00};
        root_d = {root_q[DSR_W-2:0], ge};
      end else begin
        acc_d = {acc_q[ACC_W-2:0], ge};
      end
      cnt_d = cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dsr_q  <= dsr_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign root_o = root_q;

endmodule

[rtl/core/sharpe_ratio_engine.sv]
// Streaming annualised Sharpe ratio of an equity curve.
// Samples enter on the input channel (in_valid_i / in_stall_o) one transaction
// at a time; last_sample_i marks the end of a curve. Each sample after the first
// yields a Q16.16 return (one 48-step division) if the previous sample is
// positive and the count is below its limit; each return is folded into a
// count, a sum and a sum of squares. On the last sample the block runs two
// 64-step divisions, a 32-step square root and a final 64-step division (it
// stops early with no returns or a non-positive variance), then presents
// sharpe_value_o and status_o on the output channel (out_valid_o / out_stall_i)
// and clears its accumulated state. Status 0 ok, 1 no returns, 2 zero deviation.
// in_stall_o is high whenever the sequencer is busy. The result sits in an
// output register: while the receiver stalls it holds steady and the block
// keeps taking samples, waiting only if a further result is ready to go out.
// The user writes risk_free_per_step (cfg_we_i/cfg_wdata_i) only while idle;
// not enforced by the block. Reset clears it, accumulators and output channel.
module sharpe_ratio_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_value_i,
  input  logic        last_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sharpe_value_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import sre_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RET, S_SQ, S_ACC, S_NEXT, S_FIN, S_MEAN, S_MSQ,
    S_VAR, S_SQRT, S_MUL, S_QSTART, S_QWAIT, S_EMIT
  } state_e;

  state_e state_q;

  logic [31:0]       rf_q;
  logic [31:0]       prev_q;
  logic              have_prev_q;
  logic              last_q;
  logic              ret_neg_q;
  logic [CNT_W-1:0]  count_q;
  logic [47:0]       sum_q;
  logic [ACC_W-1:0]  sqsum_q;
  logic [31:0]       r_q;
  logic [ACC_W-1:0]  sq_q;
  logic [31:0]       mean_q;
  logic [ACC_W-1:0]  amsq_q;
  logic [ACC_W-1:0]  msq_q;
  logic [DSR_W-1:0]  dev_q;
  logic signed [54:0] prod_q;
  logic [31:0]       res_q;
  logic [1:0]        stat_q;
  logic              out_valid_q;
  logic [31:0]       out_val_q;
  logic [1:0]        out_stat_q;

  unit_req_t         req;
  logic [ACC_W-1:0]  opa;
  logic [DSR_W-1:0]  opb;
  logic              u_done;
  logic [ACC_W-1:0]  u_quot;
  logic [DSR_W-1:0]  u_root;

  logic              in_acc;
  logic              do_ret;
  logic [32:0]       step_diff;
  logic [31:0]       step_mag;
  logic [31:0]       r_mag;
  logic [47:0]       sum_mag;
  logic [31:0]       mean_mag;
  logic [ACC_W:0]    var_s;
  logic signed [32:0] excess;
  logic [54:0]       prod_mag;
  logic              out_free;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign do_ret   = have_prev_q && !prev_q[31] && (prev_q != '0) && (count_q < CNT_LIMIT);
  assign step_diff = {sample_value_i[31], sample_value_i} - {prev_q[31], prev_q};
  assign step_mag = step_diff[32] ? 32'(-step_diff) : step_diff[31:0];
  assign r_mag    = r_q[31] ? 32'(-r_q) : r_q;
  assign sum_mag  = sum_q[47] ? 48'(-sum_q) : sum_q;
  assign mean_mag = mean_q[31] ? 32'(-mean_q) : mean_q;
  assign var_s    = {1'b0, msq_q} - {17'b0, amsq_q[ACC_W-1:16]};
  assign excess   = $signed({mean_q[31], mean_q}) - $signed({rf_q[31], rf_q});
  assign prod_mag = prod_q[54] ? 55'(-prod_q) : 55'(prod_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // operand and request selection for the shared unit
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.iters = ITERS_FULL;
    opa       = '0;
    opb       = '0;
    case (state_q)
      S_IDLE: begin
        req.start = in_acc && do_ret;
        req.iters = ITERS_RET;
        opa       = {step_mag, 32'h0};
        opb       = prev_q;
      end
      S_FIN: begin
        req.start = (count_q != '0);
        opa       = {16'h0, sum_mag};
        opb       = DSR_W'(count_q);
      end
      S_MEAN: begin
        req.start = u_done;
        opa       = sqsum_q;
        opb       = DSR_W'(count_q);
      end
      S_VAR: begin
        req.start = !var_s[ACC_W] && (var_s[ACC_W-1:0] != '0);
        req.op    = OP_SQRT;
        req.iters = ITERS_SQRT;
        opa       = {var_s[47:0], 16'h0};
      end
      S_QSTART: begin
        req.start = 1'b1;
        opa       = ACC_W'(prod_mag);
        opb       = dev_q;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  sre_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (u_done),
    .quot_o (u_quot),
    .root_o (u_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rf_q        <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      sqsum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rf_q <= cfg_wdata_i;
      if ((state_q == S_EMIT) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            prev_q      <= sample_value_i;
            have_prev_q <= 1'b1;
            last_q      <= last_sample_i;
            ret_neg_q   <= step_diff[32];
            state_q     <= do_ret ? S_RET : S_NEXT;
          end
        end
        S_RET: begin
          if (u_done) begin
            r_q     <= sat32(ret_neg_q, u_quot);
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sq_q    <= ACC_W'(r_mag) * ACC_W'(r_mag);
          state_q <= S_ACC;
        end
        S_ACC: begin
          count_q <= count_q + CNT_W'(1);
          sum_q   <= sum_q + {{16{r_q[31]}}, r_q};
          sqsum_q <= sqsum_q + {16'h0, sq_q[ACC_W-1:16]};
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          state_q <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (count_q == '0) begin
            res_q   <= '0;
            stat_q  <= STATUS_NO_RET;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (u_done) begin
            mean_q  <= sum_q[47] ? 32'(-u_quot[31:0]) : u_quot[31:0];
            state_q <= S_MSQ;
          end
        end
        S_MSQ: begin
          amsq_q <= ACC_W'(mean_mag) * ACC_W'(mean_mag);
          if (u_done) begin
            msq_q   <= u_quot;
            state_q <= S_VAR;
          end
        end
        S_VAR: begin
          // negative variance clamps to zero
          if (var_s[ACC_W] || (var_s[ACC_W-1:0] == '0)) begin
            res_q   <= '0;
            stat_q  <= STATUS_ZERO_DEV;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (u_done) begin
            dev_q   <= u_root;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= 55'(excess) * 55'($signed(SQRT252_Q16));
          state_q <= S_QSTART;
        end
        S_QSTART: begin
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          if (u_done) begin
            res_q   <= sat32(prod_q[54], u_quot);
            stat_q  <= STATUS_OK;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_val_q   <= res_q;
            out_stat_q  <= stat_q;
            prev_q      <= '0;
            have_prev_q <= 1'b0;
            count_q     <= '0;
            sum_q       <= '0;
            sqsum_q     <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sharpe_value_o = out_val_q;
  assign status_o       = out_stat_q;

endmodule

[rtl/core/sre_checker.sv]
// port-level checks for the sharpe ratio engine, bound to the top level
// uses sre_pkg status codes
module sre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] sharpe_value_o,
  input logic [1:0]  status_o
);
  import sre_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sharpe_value_o)
      && $stable(status_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK) || (status_o == STATUS_NO_RET)
      || (status_o == STATUS_ZERO_DEV))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> sharpe_value_o == 32'h0)
    else $error("error result not zero");

  // every accepted sample makes the sequencer busy in the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample transaction did not occupy the sequencer");

endmodule

bind sharpe_ratio_engine sre_checker u_sre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sharpe_value_o (sharpe_value_o),
  .status_o       (status_o)
);

[tb/tb_sharpe_ratio_engine.sv]
// testbench for the streaming sharpe ratio engine: random equity curves with
// random idling on both channels, checked against an in-bench predictor
// depends on sre_pkg and sharpe_ratio_engine
module tb_sharpe_ratio_engine;
  import sre_pkg::*;

  localparam int unsigned CNT_FULL   = 65535;
  localparam longint      ROOT252    = 1040352;
  localparam int          CYCLE_CAP  = 2000000;
  localparam int          DRAIN_WAIT = 400;

  typedef struct {
    logic [31:0] sharpe;
    logic [1:0]  status;
  } ratio_t;

  class ratio_board;
    ratio_t   pending[$];
    longint   risk_free;
    logic [31:0] prev_val;
    bit       have_prev;
    int unsigned n_ret;
    longint   ret_sum;
    logic [63:0] sq_sum;
    int       errors;

    function new();
      risk_free = 0;
      errors    = 0;
      clear();
    endfunction

    function void clear();
      prev_val  = '0;
      have_prev = 0;
      n_ret     = 0;
      ret_sum   = 0;
      sq_sum    = '0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_sample(logic [31:0] smp, bit last);
      longint cur, prv, r, mean, msq, vr, dev, val;
      logic [63:0] a, am;
      ratio_t res;
      cur = longint'($signed(smp));
      prv = longint'($signed(prev_val));
      if (have_prev && prv > 0 && n_ret < CNT_FULL) begin
        r = sat(((cur - prv) * 65536) / prv);
        a = (r < 0) ? -r : r;
        n_ret++;
        ret_sum += r;
        sq_sum += (a * a) >> 16;
      end
      prev_val  = smp;
      have_prev = 1;
      if (!last) return;
      val = 0;
      res.status = STATUS_OK;
      if (n_ret == 0) begin
        res.status = STATUS_NO_RET;
      end else begin
        mean = ret_sum / longint'(n_ret);
        am   = (mean < 0) ? -mean : mean;
        msq  = longint'(sq_sum / 64'(n_ret));
        vr   = msq - longint'((am * am) >> 16);
        if (vr <= 0) begin
          res.status = STATUS_ZERO_DEV;
        end else begin
          dev = longint'(root(64'(vr) << 16));
          val = sat(((mean - risk_free) * ROOT252) / dev);
        end
      end
      res.sharpe = val[31:0];
      pending.insert(pending.size(), res);
      clear();
    endfunction

    function void check(logic [31:0] sharpe, logic [1:0] status);
      ratio_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result sharpe=%h status=%0d", sharpe, status);
        return;
      end
      e = pending.pop_front();
      if (e.sharpe !== sharpe || e.status !== status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected sharpe=%h status=%0d, got sharpe=%h status=%0d",
                   e.sharpe, e.status, sharpe, status);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, last_sample_i;
  logic [31:0] sample_value_i;
  logic        out_valid_o, out_stall_i;
  logic [31:0] sharpe_value_o;
  logic [1:0]  status_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  ratio_board board;
  int  cycles;
  bit  calm;

  sharpe_ratio_engine DUT (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("sharpe_ratio_engine test failed");
        $finish;
      end
    end
  end

  // receiver side: random stalls, result checked at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check(sharpe_value_o, status_o);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 0;
    else out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 20);
  end

  task automatic send(logic [31:0] v, bit last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 20) @(negedge clk_i);
    in_valid_i     <= 1;
    sample_value_i <= v;
    last_sample_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_sample(v, last);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_risk_free(logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.risk_free = longint'($signed(v));
  endtask

  function automatic logic [31:0] rand_word();
    return {$urandom()};
  endfunction

  // mostly positive values drifting by random steps, with random and negative words
  task automatic random_curve(int len);
    logic [31:0] v;
    int shift;
    v = $urandom_range(1000, 1 << 20);
    for (int k = 0; k < len; k++) begin
      shift = $urandom_range(2, 10);
      case ($urandom_range(9))
        0: send(rand_word(), k == len - 1);
        1: send(32'(-$signed({1'b0, $urandom_range(1000)})), k == len - 1);
        default: begin
          v = v + 32'($signed($urandom_range(0, 2 * (v >> shift))) - $signed(v >> shift));
          if ($signed(v) <= 0) v = 1;
          send(v, k == len - 1);
        end
      endcase
    end
  endtask

  initial begin
    int sent;
    board = new();
    calm = 0;
    rst_ni = 0;
    in_valid_i = 0;
    sample_value_i = '0;
    last_sample_i = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: last on first sample, flat curve, non-positive previous, extremes
    send(32'd100, 1);
    send(32'd100, 0); send(32'd100, 0); send(32'd100, 1);
    send(32'd0, 0); send(32'hFFFF_FF00, 0); send(32'd5, 1);
    send(32'd1, 0); send(32'h7FFF_FFFF, 0); send(32'h8000_0000, 0);
    send(32'd1, 0); send(32'd3, 1);
    send(32'd1000, 0); send(32'd1100, 0); send(32'd990, 0); send(32'd1200, 1);
    set_risk_free(32'h7FFF_FFFF);
    send(32'd10, 0); send(32'd20, 0); send(32'd15, 1);
    set_risk_free(32'h8000_0000);
    send(32'd10, 0); send(32'd9, 0); send(32'd30, 1);
    set_risk_free(32'd0);

    sent = 25;
    while (sent < 700) begin
      int len;
      len = $urandom_range(1, 12);
      if (sent > 300 && sent < 400) calm = 1;
      else calm = 0;
      random_curve(len);
      sent += len;
      if ($urandom_range(9) == 0) set_risk_free(($urandom_range(3) == 0) ? rand_word()
                                                : 32'($signed($urandom_range(0, 2000)) - 1000));
    end
    drain();
    if (board.errors == 0) $display("sharpe_ratio_engine test passed");
    else $display("sharpe_ratio_engine test failed");
    $finish;
  end
endmodule
